>>> design/acu_pkg.sv
// Package for the address counter unit: sizes, opcode codes and beat types.
// Used by address_counter_unit; depends on nothing else.
package acu_pkg;

  localparam int NUM_SETS      = 3;
  localparam int COUNTER_BITS  = 32;
  localparam int SET_MASK_BITS = 3;
  localparam int LANES         = 8;
  localparam int QUAD_LANES    = 4;
  // Only sets that both exist and have a mask bit can ever be touched.
  localparam int SEL_SETS  = (NUM_SETS < SET_MASK_BITS) ? NUM_SETS : SET_MASK_BITS;
  localparam int SET_IDX_W = (SEL_SETS > 1) ? $clog2(SEL_SETS) : 1;

  typedef logic [COUNTER_BITS-1:0] cnt_t;

  typedef enum logic [2:0] {
    OP_SET_ONE  = 3'd0,
    OP_SET_XY   = 3'd1,
    OP_INC_XY   = 3'd2,
    OP_CR_XY    = 3'd3,
    OP_SET_ZW   = 3'd4,
    OP_INC_ZW   = 3'd5,
    OP_CR_ZW    = 3'd6,
    OP_SET_XEND = 3'd7
  } opcode_t;

  typedef struct packed {
    logic [2:0]  opcode;
    logic [2:0]  set_mask;
    logic        channel_sel;
    logic [1:0]  dimension_sel;
    logic [31:0] single_value;
    logic [31:0] ch1_upper_val;
    logic [31:0] ch1_lower_val;
    logic [31:0] ch0_upper_val;
    logic [31:0] ch0_lower_val;
    logic [3:0]  lane_mask;
  } in_beat_t;

  typedef struct packed {
    logic [1:0]  shown_set;
    logic        none_selected;
    logic [31:0] out_ch0_x;
    logic [31:0] out_ch0_y;
    logic [31:0] out_ch0_z;
    logic [31:0] out_ch0_w;
    logic [31:0] out_ch1_x;
    logic [31:0] out_ch1_y;
    logic [31:0] out_ch1_z;
    logic [31:0] out_ch1_w;
    logic [31:0] out_x_end;
  } out_beat_t;

endpackage

>>> design/address_counter_unit.sv
// Address counter unit: executes counter instructions on the counter sets.
// Depends on acu_pkg.
//
// Each input beat is one instruction. It is captured in an input register,
// then executed by one level of adders and lane muxes that update every
// selected set at once, and its report lands in an output register. A new
// instruction can be taken every cycle while the output is not stalled, so
// the sustained rate is one instruction per cycle. The report passes through
// the input register and then the output register; only a stalled output
// slows the input side.
// Counters, bases and X end values reset to zero. The report shows the lowest
// selected set after the instruction, or set 0 with none_selected high.
module address_counter_unit (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  acu_pkg::in_beat_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output acu_pkg::out_beat_t out_data
);

  acu_pkg::in_beat_t item;
  logic              item_valid;
  logic              advance;

  acu_pkg::cnt_t cnt       [acu_pkg::SEL_SETS][acu_pkg::LANES];
  acu_pkg::cnt_t base      [acu_pkg::SEL_SETS][acu_pkg::LANES];
  acu_pkg::cnt_t x_end     [acu_pkg::SEL_SETS];
  acu_pkg::cnt_t cnt_next  [acu_pkg::SEL_SETS][acu_pkg::LANES];
  acu_pkg::cnt_t base_next [acu_pkg::SEL_SETS][acu_pkg::LANES];
  acu_pkg::cnt_t x_end_next[acu_pkg::SEL_SETS];

  logic [acu_pkg::SET_IDX_W-1:0] shown;
  logic                          any_sel;
  acu_pkg::out_beat_t            result_next;

  assign advance  = item_valid && (!out_valid || out_ready);
  assign in_ready = !item_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (in_ready) begin
      item_valid <= in_valid;
    end
    if (in_ready && in_valid) begin
      item <= in_data;
    end
  end

  // Lane l of a set: channel l[2], dimension l[1:0]. Four-lane opcodes cover
  // the X/Y or Z/W half, picked by dimension bit 1; operand index is
  // {channel, dimension bit 0}.
  always_comb begin
    acu_pkg::cnt_t quad_val[acu_pkg::QUAD_LANES];
    acu_pkg::opcode_t op;
    logic in_group;
    logic [1:0] j;
    logic [2:0] lane;
    acu_pkg::cnt_t v;
    acu_pkg::cnt_t single;

    op          = acu_pkg::opcode_t'(item.opcode);
    quad_val[0] = acu_pkg::COUNTER_BITS'(item.ch0_lower_val);
    quad_val[1] = acu_pkg::COUNTER_BITS'(item.ch0_upper_val);
    quad_val[2] = acu_pkg::COUNTER_BITS'(item.ch1_lower_val);
    quad_val[3] = acu_pkg::COUNTER_BITS'(item.ch1_upper_val);
    single      = acu_pkg::COUNTER_BITS'(item.single_value);

    for (int s = 0; s < acu_pkg::SEL_SETS; s++) begin
      x_end_next[s] = x_end[s];
      for (int l = 0; l < acu_pkg::LANES; l++) begin
        lane = 3'(l);
        j    = {lane[2], lane[0]};
        v    = quad_val[j];
        cnt_next[s][l]  = cnt[s][l];
        base_next[s][l] = base[s][l];
        in_group = 1'b0;
        case (op)
          acu_pkg::OP_SET_XY, acu_pkg::OP_INC_XY, acu_pkg::OP_CR_XY:
            in_group = !lane[1];
          acu_pkg::OP_SET_ZW, acu_pkg::OP_INC_ZW, acu_pkg::OP_CR_ZW:
            in_group = lane[1];
          default: in_group = 1'b0;
        endcase
        if (item.set_mask[s]) begin
          case (op)
            acu_pkg::OP_SET_ONE: begin
              if (lane == {item.channel_sel, item.dimension_sel}) begin
                cnt_next[s][l]  = single;
                base_next[s][l] = single;
              end
            end
            acu_pkg::OP_SET_XY, acu_pkg::OP_SET_ZW: begin
              if (in_group && item.lane_mask[j]) begin
                cnt_next[s][l]  = v;
                base_next[s][l] = v;
              end
            end
            // Increments ignore the lane mask and leave the base alone.
            acu_pkg::OP_INC_XY, acu_pkg::OP_INC_ZW: begin
              if (in_group) begin
                cnt_next[s][l] = cnt[s][l] + v;
              end
            end
            acu_pkg::OP_CR_XY, acu_pkg::OP_CR_ZW: begin
              if (in_group && item.lane_mask[j]) begin
                base_next[s][l] = base[s][l] + v;
                cnt_next[s][l]  = base[s][l] + v;
              end
            end
            acu_pkg::OP_SET_XEND: begin
              // Channel 0 X counter only; its base is not written.
              if (l == 0) begin
                cnt_next[s][l] = quad_val[0];
                x_end_next[s]  = quad_val[1];
              end
            end
            default: ;
          endcase
        end
      end
    end
  end

  always_comb begin
    shown   = '0;
    any_sel = 1'b0;
    for (int s = acu_pkg::SEL_SETS - 1; s >= 0; s--) begin
      if (item.set_mask[s]) begin
        shown   = acu_pkg::SET_IDX_W'(s);
        any_sel = 1'b1;
      end
    end
    result_next.shown_set     = 2'(shown);
    result_next.none_selected = !any_sel;
    result_next.out_ch0_x     = 32'(cnt_next[shown][0]);
    result_next.out_ch0_y     = 32'(cnt_next[shown][1]);
    result_next.out_ch0_z     = 32'(cnt_next[shown][2]);
    result_next.out_ch0_w     = 32'(cnt_next[shown][3]);
    result_next.out_ch1_x     = 32'(cnt_next[shown][4]);
    result_next.out_ch1_y     = 32'(cnt_next[shown][5]);
    result_next.out_ch1_z     = 32'(cnt_next[shown][6]);
    result_next.out_ch1_w     = 32'(cnt_next[shown][7]);
    result_next.out_x_end     = 32'(x_end_next[shown]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      for (int s = 0; s < acu_pkg::SEL_SETS; s++) begin
        x_end[s] <= '0;
        for (int l = 0; l < acu_pkg::LANES; l++) begin
          cnt[s][l]  <= '0;
          base[s][l] <= '0;
        end
      end
    end else begin
      if (advance) begin
        out_valid <= 1'b1;
        cnt       <= cnt_next;
        base      <= base_next;
        x_end     <= x_end_next;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
    if (advance) begin
      out_data <= result_next;
    end
  end

endmodule
